### sv/msqrt_pkg.sv
package msqrt_pkg;
  localparam int unsigned MOD_BITS = 31;
  localparam int unsigned VAL_BITS = 32;
  localparam int unsigned CNT_BITS = 6;
  localparam int unsigned ZL = 2 * MOD_BITS * MOD_BITS;
  localparam int unsigned ZL_BITS = $clog2(ZL + 1);
  typedef logic [MOD_BITS-1:0] mod_t;

  typedef struct packed {
    logic start;
    mod_t a;
    mod_t b;
    mod_t p;
  } mul_req_t;
endpackage

### sv/msqrt_if.sv
interface msqrt_in_if;
  logic valid;
  logic ready;
  logic signed [msqrt_pkg::VAL_BITS-1:0] value;
  msqrt_pkg::mod_t modulus;
  modport source(output valid, output value, output modulus, input ready);
  modport sink(input valid, input value, input modulus, output ready);
endinterface

interface msqrt_out_if;
  logic valid;
  logic ready;
  msqrt_pkg::mod_t root;
  logic no_root;
  modport source(output valid, output root, output no_root, input ready);
  modport sink(input valid, input root, input no_root, output ready);
endinterface

### sv/msqrt_mul.sv
// bit-serial modular multiply, one multiplier bit per cycle, lsb first
module msqrt_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  msqrt_pkg::mul_req_t  req,
  output logic                 done,
  output msqrt_pkg::mod_t      prod
);
  logic [msqrt_pkg::MOD_BITS:0] acc_r, acc_nxt, a_r, a_nxt;
  msqrt_pkg::mod_t b_r, b_nxt, p_r, p_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [msqrt_pkg::MOD_BITS:0] sum, dbl;

  always_comb begin
    sum = acc_r + a_r;
    if (sum >= {1'b0, p_r}) sum = sum - {1'b0, p_r};
    dbl = {a_r[msqrt_pkg::MOD_BITS-1:0], 1'b0};
    if (dbl >= {1'b0, p_r}) dbl = dbl - {1'b0, p_r};
    acc_nxt = acc_r;
    a_nxt = a_r;
    b_nxt = b_r;
    p_nxt = p_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      acc_nxt = '0;
      a_nxt = {1'b0, req.a};
      b_nxt = req.b;
      p_nxt = req.p;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (b_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        if (b_r[0]) acc_nxt = sum;
        a_nxt = dbl;
        b_nxt = b_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    p_r <= p_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r[msqrt_pkg::MOD_BITS-1:0];
endmodule

### sv/modular_square_root_top.sv
// channel  dir  payload
// in_      in   value (32 signed), modulus (31)
// out_     out  root (31), no_root (1)
// one item at a time: a bit-serial reduction, modular multiplies (issue, one multiplier
// bit per cycle, done, take), one exponentiation of one or two multiplies per exponent bit
// for each legendre check or nonresidue candidate, plus up to about k squared multiplies
// in the main loop
// a result waits in the output register and holds off the next item until taken,
// in the same cycle at the earliest; synchronous active-low reset returns to idle
module modular_square_root_top (
  input  logic clk,
  input  logic rst_n,
  msqrt_in_if.sink    in_ch,
  msqrt_out_if.source out_ch
);
  localparam int unsigned MB = msqrt_pkg::MOD_BITS;
  localparam int unsigned CB = msqrt_pkg::CNT_BITS;
  localparam int unsigned ZB = msqrt_pkg::ZL_BITS;
  localparam logic [4:0] S_IDLE = 5'd0, S_RED = 5'd1, S_FIX = 5'd2, S_CHK = 5'd3,
    S_LEG = 5'd4, S_KS = 5'd5, S_ZT = 5'd6, S_ZC = 5'd7, S_PB = 5'd8,
    S_PY = 5'd9, S_PX = 5'd10, S_LOOP = 5'd11, S_ORD = 5'd12, S_SQY = 5'd13,
    S_UPX = 5'd14, S_UPY = 5'd15, S_UPB = 5'd16, S_OUT = 5'd17, S_FAIL = 5'd18,
    S_POW = 5'd19, S_PWM = 5'd20, S_PWS = 5'd21;

  logic [4:0] st_r, st_nxt, ret_r, ret_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] mag_r, mag_nxt;
  logic neg_r, neg_nxt;
  logic [5:0] bc_r, bc_nxt;
  msqrt_pkg::mod_t p_r, p_nxt, a_r, a_nxt, s_r, s_nxt, z_r, z_nxt;
  msqrt_pkg::mod_t x_r, x_nxt, b_r, b_nxt, y_r, y_nxt, c_r, c_nxt;
  msqrt_pkg::mod_t pw_b_r, pw_b_nxt, pw_e_r, pw_e_nxt, pw_acc_r, pw_acc_nxt;
  logic [CB-1:0] k_r, k_nxt, m_r, m_nxt, r_r, r_nxt, it_r, it_nxt, j_r, j_nxt;
  logic [ZB-1:0] zl_r, zl_nxt;
  logic mw_r, mw_nxt;
  logic ov_r, ov_nxt;
  msqrt_pkg::mod_t root_r, root_nxt;
  logic nr_r, nr_nxt;
  msqrt_pkg::mul_req_t req;
  logic mdone;
  msqrt_pkg::mod_t prod;
  logic [32:0] trial;
  msqrt_pkg::mod_t pm1, h;

  msqrt_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .prod(prod));

  assign pm1 = p_r - 1'b1;
  assign h = pm1 >> 1;
  assign in_ch.ready = (st_r == S_IDLE) && !(ov_r && !out_ch.ready);
  assign out_ch.valid = ov_r;
  assign out_ch.root = root_r;
  assign out_ch.no_root = nr_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; rem_nxt = rem_r; mag_nxt = mag_r; neg_nxt = neg_r;
    bc_nxt = bc_r; p_nxt = p_r; a_nxt = a_r; s_nxt = s_r; z_nxt = z_r; x_nxt = x_r;
    b_nxt = b_r; y_nxt = y_r; c_nxt = c_r; pw_b_nxt = pw_b_r; pw_e_nxt = pw_e_r;
    pw_acc_nxt = pw_acc_r; k_nxt = k_r; m_nxt = m_r; r_nxt = r_r; it_nxt = it_r;
    j_nxt = j_r; zl_nxt = zl_r; mw_nxt = mw_r;
    root_nxt = root_r; nr_nxt = nr_r;
    ov_nxt = ov_r && !out_ch.ready;
    req = '0;
    req.p = p_r;
    trial = {rem_r[31:0], mag_r[31]} - {2'b0, p_r};
    unique case (st_r)
      S_IDLE: if (in_ch.valid && in_ch.ready) begin
        p_nxt = in_ch.modulus;
        neg_nxt = in_ch.value[31];
        mag_nxt = in_ch.value[31] ? 32'(-in_ch.value) : in_ch.value;
        rem_nxt = '0;
        bc_nxt = '0;
        st_nxt = (in_ch.modulus < MB'(2)) ? S_FAIL : S_RED;
      end
      S_RED: begin
        if (!trial[32]) rem_nxt = trial;
        else rem_nxt = {rem_r[31:0], mag_r[31]};
        mag_nxt = mag_r << 1;
        bc_nxt = bc_r + 1'b1;
        if (bc_r == 6'd31) st_nxt = S_FIX;
      end
      S_FIX: begin
        a_nxt = rem_r[MB-1:0];
        if (neg_r && rem_r != '0) a_nxt = p_r - rem_r[MB-1:0];
        st_nxt = S_CHK;
      end
      S_CHK: begin
        if (a_r == '0) begin
          root_nxt = '0; nr_nxt = 1'b0; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (p_r == MB'(2)) begin
          root_nxt = MB'(1); nr_nxt = 1'b0; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (pm1[0]) st_nxt = S_FAIL;
        else begin
          pw_b_nxt = a_r; pw_e_nxt = h; pw_acc_nxt = MB'(1);
          mw_nxt = 1'b0; ret_nxt = S_LEG; st_nxt = S_POW;
        end
      end
      S_LEG: if (pw_acc_r != MB'(1)) st_nxt = S_FAIL;
        else begin
          s_nxt = pm1; k_nxt = '0; st_nxt = S_KS;
        end
      S_KS: if (!s_r[0]) begin
          s_nxt = s_r >> 1; k_nxt = k_r + 1'b1;
        end else begin
          z_nxt = MB'(2);
          zl_nxt = ZB'(msqrt_pkg::ZL);
          if ({1'b0, pm1} < (MB+1)'(msqrt_pkg::ZL)) zl_nxt = ZB'(pm1);
          st_nxt = S_ZT;
        end
      S_ZT: if ({1'b0, z_r} > (MB+1)'(zl_r)) st_nxt = S_FAIL;
        else begin
          pw_b_nxt = z_r; pw_e_nxt = h; pw_acc_nxt = MB'(1);
          mw_nxt = 1'b0; ret_nxt = S_ZC; st_nxt = S_POW;
        end
      S_ZC: if (pw_acc_r == pm1) begin
          pw_b_nxt = a_r; pw_e_nxt = s_r; pw_acc_nxt = MB'(1);
          mw_nxt = 1'b0; ret_nxt = S_PB; st_nxt = S_POW;
        end else begin
          z_nxt = z_r + 1'b1; st_nxt = S_ZT;
        end
      S_PB: begin
        b_nxt = pw_acc_r;
        pw_b_nxt = z_r; pw_e_nxt = s_r; pw_acc_nxt = MB'(1);
        mw_nxt = 1'b0; ret_nxt = S_PY; st_nxt = S_POW;
      end
      S_PY: begin
        y_nxt = pw_acc_r;
        pw_b_nxt = a_r; pw_e_nxt = (s_r + 1'b1) >> 1; pw_acc_nxt = MB'(1);
        mw_nxt = 1'b0; ret_nxt = S_PX; st_nxt = S_POW;
      end
      S_PX: begin
        x_nxt = pw_acc_r; it_nxt = '0; m_nxt = '0; st_nxt = S_LOOP;
      end
      S_LOOP: if (b_r == MB'(1)) begin
          root_nxt = x_r; nr_nxt = 1'b0; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (it_r >= k_r) st_nxt = S_FAIL;
        else begin
          r_nxt = '0; c_nxt = b_r; mw_nxt = 1'b0; st_nxt = S_ORD;
        end
      S_ORD: if (!mw_r) begin
          if (c_r != MB'(1) && r_r < k_r) begin
            req.start = 1'b1; req.a = c_r; req.b = c_r; mw_nxt = 1'b1;
          end else if (c_r != MB'(1) || (CB+1)'(r_r) + (CB+1)'(m_r) + 1'b1 > (CB+1)'(k_r))
            st_nxt = S_FAIL;
          else begin
            j_nxt = '0; st_nxt = S_SQY;
          end
        end else if (mdone) begin
          c_nxt = prod; r_nxt = r_r + 1'b1; mw_nxt = 1'b0;
        end
      S_SQY: if (!mw_r) begin
          if (j_r < k_r - r_r - m_r - 1'b1) begin
            req.start = 1'b1; req.a = y_r; req.b = y_r; mw_nxt = 1'b1;
          end else begin
            m_nxt = k_r - r_r; st_nxt = S_UPX;
          end
        end else if (mdone) begin
          y_nxt = prod; j_nxt = j_r + 1'b1; mw_nxt = 1'b0;
        end
      S_UPX: if (!mw_r) begin
          req.start = 1'b1; req.a = x_r; req.b = y_r; mw_nxt = 1'b1;
        end else if (mdone) begin
          x_nxt = prod; mw_nxt = 1'b0; st_nxt = S_UPY;
        end
      S_UPY: if (!mw_r) begin
          req.start = 1'b1; req.a = y_r; req.b = y_r; mw_nxt = 1'b1;
        end else if (mdone) begin
          y_nxt = prod; mw_nxt = 1'b0; st_nxt = S_UPB;
        end
      S_UPB: if (!mw_r) begin
          req.start = 1'b1; req.a = b_r; req.b = y_r; mw_nxt = 1'b1;
        end else if (mdone) begin
          b_nxt = prod; mw_nxt = 1'b0; it_nxt = it_r + 1'b1; st_nxt = S_LOOP;
        end
      S_POW: if (pw_e_r == '0) st_nxt = ret_r;
        else if (pw_e_r[0]) st_nxt = S_PWM;
        else st_nxt = S_PWS;
      S_PWM: if (!mw_r) begin
          req.start = 1'b1; req.a = pw_acc_r; req.b = pw_b_r; mw_nxt = 1'b1;
        end else if (mdone) begin
          pw_acc_nxt = prod; mw_nxt = 1'b0; st_nxt = S_PWS;
        end
      S_PWS: if (!mw_r) begin
          req.start = 1'b1; req.a = pw_b_r; req.b = pw_b_r; mw_nxt = 1'b1;
        end else if (mdone) begin
          pw_b_nxt = prod; pw_e_nxt = pw_e_r >> 1; mw_nxt = 1'b0; st_nxt = S_POW;
        end
      S_FAIL: begin
        root_nxt = '0; nr_nxt = 1'b1; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r != S_IDLE && st_nxt == S_IDLE && ov_r && !out_ch.ready) begin
      st_nxt = st_r; root_nxt = root_r; nr_nxt = nr_r; ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt; rem_r <= rem_nxt; mag_r <= mag_nxt; neg_r <= neg_nxt;
    bc_r <= bc_nxt; p_r <= p_nxt; a_r <= a_nxt; s_r <= s_nxt; z_r <= z_nxt;
    x_r <= x_nxt; b_r <= b_nxt; y_r <= y_nxt; c_r <= c_nxt; pw_b_r <= pw_b_nxt;
    pw_e_r <= pw_e_nxt; pw_acc_r <= pw_acc_nxt; k_r <= k_nxt; m_r <= m_nxt;
    r_r <= r_nxt; it_r <= it_nxt; j_r <= j_nxt; zl_r <= zl_nxt;
    root_r <= root_nxt; nr_r <= nr_nxt;
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; mw_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; mw_r <= mw_nxt;
    end
  end
endmodule

### bench/modular_square_root_top_tb.sv
module modular_square_root_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MB = msqrt_pkg::MOD_BITS;
  localparam int unsigned VB = msqrt_pkg::VAL_BITS;
  localparam int unsigned STALL_LIMIT = 1000000;
  localparam longint unsigned SEARCH_CAP = 2 * MB * MB;

  typedef struct {
    msqrt_pkg::mod_t root;
    logic no_root;
  } root_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msqrt_in_if  in_ch();
  msqrt_out_if out_ch();

  modular_square_root_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  root_t root_q[$];
  int unsigned mismatches = 0;
  int unsigned hold_len = 0;
  int unsigned hold_cycles = 0;
  bit hold_taken = 1'b0;
  int unsigned quiet_cycles = 0;
  bit no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned mul_mod(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
    return ((a % p) * (b % p)) % p;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned e,
                                              longint unsigned p);
    longint unsigned acc;
    acc = 1 % p;
    base = base % p;
    while (e != 0) begin
      if (e[0]) acc = mul_mod(acc, base, p);
      base = mul_mod(base, base, p);
      e = e >> 1;
    end
    return acc;
  endfunction

  // tonelli-shanks with the same bounded search and early exits as the block
  function automatic bit shanks(longint unsigned a, longint unsigned p,
                                output longint unsigned root);
    longint unsigned s, h, z, lim, x, b, y, c;
    int unsigned k, m, r, it;
    bit found;
    k = 0;
    m = 0;
    found = 1'b0;
    root = 0;
    s = p - 1;
    if (s[0]) return 1'b0;
    h = s >> 1;
    if (pow_mod(a, h, p) != 1) return 1'b0;
    while (!s[0]) begin
      s = s >> 1;
      k++;
    end
    lim = (SEARCH_CAP > p - 1) ? p - 1 : SEARCH_CAP;
    for (z = 2; z <= lim; z++) begin
      if (pow_mod(z, h, p) == p - 1) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) return 1'b0;
    b = pow_mod(a, s, p);
    y = pow_mod(z, s, p);
    x = pow_mod(a, (s + 1) >> 1, p);
    for (it = 0; it < k && b != 1; it++) begin
      r = 0;
      c = b;
      while (c != 1 && r < k) begin
        c = mul_mod(c, c, p);
        r++;
      end
      if (c != 1 || r + m + 1 > k) return 1'b0;
      for (int unsigned j = 0; j < k - r - m - 1; j++) y = mul_mod(y, y, p);
      m = k - r;
      x = mul_mod(x, y, p);
      y = mul_mod(y, y, p);
      b = mul_mod(b, y, p);
    end
    if (b != 1) return 1'b0;
    root = x;
    return 1'b1;
  endfunction

  function automatic root_t predict_root(logic signed [VB-1:0] value,
                                         msqrt_pkg::mod_t modulus);
    root_t res;
    longint v, rem;
    longint unsigned p, a, x;
    res.root = '0;
    res.no_root = 1'b1;
    p = 64'(modulus);
    if (p < 2) return res;
    v = 64'(value);
    rem = v % longint'(p);
    if (rem < 0) rem += longint'(p);
    a = rem;
    res.no_root = 1'b0;
    if (a == 0) return res;
    if (p == 2) begin
      res.root = MB'(1);
      return res;
    end
    if (shanks(a, p, x)) res.root = MB'(x);
    else res.no_root = 1'b1;
    return res;
  endfunction

  function automatic bit is_prime(longint unsigned n);
    if (n < 2) return 1'b0;
    if (n < 4) return 1'b1;
    if (!n[0]) return 1'b0;
    for (longint unsigned d = 3; d * d <= n; d += 2) if (n % d == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic msqrt_pkg::mod_t next_prime(longint unsigned n);
    if (n < 3) n = 3;
    n = n | 1;
    while (!is_prime(n)) n += 2;
    return MB'(n);
  endfunction

  task automatic send_item(logic signed [VB-1:0] value, msqrt_pkg::mod_t modulus);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.value = value;
    in_ch.modulus = modulus;
    do @(posedge clk); while (!in_ch.ready);
    root_q.push_back(predict_root(value, modulus));
    @(negedge clk);
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // receiver side
  always @(negedge clk) begin
    if (hold_cycles != 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (hold_len != 0 && !hold_taken) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_len;
      hold_taken <= 1'b1;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 7;
    end
  end

  always @(posedge clk) begin
    root_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (root_q.size() == 0) begin
        report_mismatch("unexpected item", 64'(out_ch.root), 64'd0);
      end else begin
        want = root_q.pop_front();
        if (out_ch.root !== want.root)
          report_mismatch("root", 64'(out_ch.root), 64'(want.root));
        if (out_ch.no_root !== want.no_root)
          report_mismatch("no_root", 64'(out_ch.no_root), 64'(want.no_root));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_corner_cases();
    send_item(32'sd0, 31'd0);
    send_item(32'sd5, 31'd1);
    send_item(-32'sd1, 31'd1);
    send_item(32'sd3, 31'd2);
    send_item(32'sh80000000, 31'd2);
    send_item(32'sd4, 31'd2);
    send_item(32'sd0, 31'd7);
    send_item(32'sd2, 31'd7);
    send_item(32'sd3, 31'd7);
    send_item(-32'sd1, 31'd5);
    send_item(32'sd2147483647, 31'd2147483647);
    send_item(32'sh80000000, 31'd2147483647);
    send_item(32'sd2, 31'd2147483647);
    send_item(32'sd4, 31'd2013265921);
    send_item(-32'sd1, 31'd2013265921);
    send_item(32'sd7, 31'd17);
    send_item(32'sd2147483647, 31'd97);
    send_item(32'sd10, 31'd16);
    send_item(32'sd3, 31'd4);
    send_item(32'sd4, 31'd15);
    send_item(32'sd1, 31'd9);
    send_item(-32'sd7, 31'd33);
  endtask

  task automatic test_backpressure();
    hold_len = 30000;
    for (int i = 0; i < 6; i++) send_item($urandom, next_prime(64'($urandom_range(1000, 3))));
  endtask

  task automatic test_random_items(int unsigned count);
    msqrt_pkg::mod_t p;
    longint unsigned pl, x;
    logic signed [VB-1:0] value;
    int unsigned pick;
    for (int unsigned i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 2);
      pick = $urandom_range(99);
      if (pick < 80) begin
        if ($urandom_range(2) == 0) p = next_prime(64'($urandom_range(200, 3)));
        else p = next_prime(64'($urandom_range(2147483000, 3)));
        pl = 64'(p);
        if ($urandom_range(1) == 0) begin
          x = 64'($urandom_range(32'(pl - 1)));
          value = VB'(mul_mod(x, x, pl));
          if ($urandom_range(1) == 0) value = value - VB'(pl);
        end else begin
          value = $urandom;
        end
      end else if (pick < 88) begin
        p = MB'($urandom_range(2));
        value = $urandom;
      end else begin
        p = MB'($urandom_range(120, 4));
        value = $urandom;
      end
      send_item(value, p);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.modulus = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_corner_cases();
    test_backpressure();
    test_random_items(100);
    in_ch.valid = 1'b0;
    while (root_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
